// ===== src/aicv_pkg.sv =====
// Shared types, constants and helpers for the animated image container validator.
`default_nettype none
package aicv_pkg;

   localparam int LENGTH_BYTES      = 8;
   localparam int DATE_BYTES        = 6;
   localparam int PIXEL_BYTES       = 3;
   localparam int MAIN_HEADER_BYTES = 20;
   localparam int MAGIC_BYTES       = 4;
   localparam int FIFO_DEPTH        = 4;

   localparam logic [7:0] ID_HEADER  = 8'd1;
   localparam logic [7:0] ID_CREDITS = 8'd2;
   localparam logic [7:0] ID_ANIM    = 8'd3;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [3:0] E_HTYPE    = 4'd0;
   localparam logic [3:0] E_BLOCKLEN = 4'd1;
   localparam logic [3:0] E_MAGIC    = 4'd2;
   localparam logic [3:0] E_HSIZE    = 4'd3;
   localparam logic [3:0] E_BTYPE    = 4'd4;
   localparam logic [3:0] E_CREATOR  = 4'd5;
   localparam logic [3:0] E_MANY     = 4'd6;
   localparam logic [3:0] E_IHDR     = 4'd7;
   localparam logic [3:0] E_CONTENT  = 4'd8;
   localparam logic [3:0] E_MISMATCH = 4'd9;
   localparam logic [3:0] E_CAPTION  = 4'd10;
   localparam logic [3:0] E_TAG      = 4'd11;
   localparam logic [3:0] E_HDREND   = 4'd12;
   localparam logic [3:0] E_TRUNC    = 4'd13;
   localparam logic [3:0] E_FEW      = 4'd14;

   localparam logic [2:0] CSR_FILE_LENGTH  = 3'd0;
   localparam logic [2:0] CSR_MAX_CREATOR  = 3'd1;
   localparam logic [2:0] CSR_MAX_IHEADER  = 3'd2;
   localparam logic [2:0] CSR_MAX_CONTENT  = 3'd3;
   localparam logic [2:0] CSR_MAX_CAPTION  = 3'd4;
   localparam logic [2:0] CSR_MAX_TAG      = 3'd5;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  error_code;
      logic [15:0] image_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [15:0] images_found;
      logic        end_of_file;
   } rsp_type;

   typedef struct packed {
      logic [31:0] file_length;
      logic [15:0] max_creator_length;
      logic [15:0] max_image_header_size;
      logic [31:0] max_image_content_size;
      logic [15:0] max_caption_length;
      logic [15:0] max_tag_length;
   } cfg_type;

   function automatic logic [7:0] main_magic(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h43;
         2'd1:    r = 8'h41;
         default: r = 8'h46;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] image_magic(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h43;
         2'd1:    r = 8'h49;
         default: r = 8'h46;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/aicv_parser.sv =====
// Byte parser: container structure, limit checks and result generation.
`default_nettype none
module aicv_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_accept,
   input  aicv_pkg::req_type     in_data,
   input  aicv_pkg::cfg_type     cfg,
   output logic [1:0]            push_count,
   output aicv_pkg::rsp_type     push_first,
   output aicv_pkg::rsp_type     push_second
);

   typedef enum logic [4:0] {
      PH_HTYPE, PH_HLEN, PH_MAGIC, PH_HSIZE, PH_HCOUNT, PH_BOUND, PH_BLEN,
      PH_DATE, PH_CLEN, PH_CREATOR, PH_DUR, PH_IMAGIC, PH_IHSIZE, PH_ICSIZE,
      PH_IW, PH_IH, PH_CAPTION, PH_TAG, PH_PIXEL, PH_DRAIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] offset_ff, offset_in;
   logic [7:0]  btype_ff, btype_in;
   logic [63:0] declared_ff, declared_in;
   logic [15:0] seen_ff, seen_in;
   logic [32:0] hend_ff, hend_in;
   logic [31:0] content_ff, content_in;
   logic [31:0] wlo_ff, wlo_in;
   logic        whi_ff, whi_in;
   logic        hhi_ff, hhi_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] strcnt_ff, strcnt_in;
   logic [31:0] pixleft_ff, pixleft_in;
   logic [1:0]  pixphase_ff, pixphase_in;
   logic [15:0] partial_ff, partial_in;
   logic        err_ff, err_in;
   logic [3:0]  code_ff, code_in;
   logic        clear_run;

   logic [7:0]  b;
   logic        fin;
   logic [32:0] pos1;
   logic [32:0] fl33;
   logic [63:0] v;
   logic        gdone;
   logic [31:0] remain;
   logic        len_bad;
   logic        e;
   logic [3:0]  ecode;
   logic        pix_emit;
   logic        stat_emit;
   logic [1:0]  stat_kind;
   logic [3:0]  stat_code;
   logic        stat_eof;
   logic [7:0]  pix_blue;
   logic        term;
   logic        is_cap;
   logic [15:0] lim;
   logic        h_hi;
   logic        w_zero;
   logic        h_zero;
   logic [33:0] triple;
   logic        match;
   logic [39:0] part;
   logic [15:0] sdec;
   logic [63:0] seen64;

   always_comb begin
      b      = in_data.byte_value;
      fin    = in_data.is_final;
      pos1   = {1'b0, offset_ff} + 33'd1;
      fl33   = {1'b0, cfg.file_length};
      v      = acc_ff | ({56'd0, b} << {cnt_ff[2:0], 3'b000});
      gdone  = (cnt_ff[2:0] == 3'(aicv_pkg::LENGTH_BYTES - 1));
      remain = cfg.file_length - offset_ff - 32'd1;
      len_bad = (v[63:32] != 32'd0) || (v[31:0] > remain);
      is_cap = (phase_ff == PH_CAPTION);
      term   = is_cap ? (b == aicv_pkg::CHAR_NL) : (b == aicv_pkg::CHAR_NUL);
      lim    = is_cap ? cfg.max_caption_length : cfg.max_tag_length;
      h_hi   = hhi_ff || (b != 8'd0);
      w_zero = (wlo_ff == 32'd0) && !whi_ff;
      h_zero = (v[31:0] == 32'd0) && !h_hi;
      triple = {prod_ff[31:0], 1'b0} + {2'b00, prod_ff[31:0]};
      if (w_zero || h_zero) begin
         match = (content_ff == 32'd0);
      end else begin
         match = !whi_ff && !h_hi && (prod_ff[63:32] == 32'd0)
                 && (triple == {2'b00, content_ff});
      end
      part   = {8'd0, wlo_ff} * {32'd0, b};
      sdec   = (strcnt_ff != 16'd0) ? strcnt_ff - 16'd1 : 16'd0;
      seen64 = {48'd0, seen_ff};

      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      offset_in   = offset_ff;
      btype_in    = btype_ff;
      declared_in = declared_ff;
      seen_in     = seen_ff;
      hend_in     = hend_ff;
      content_in  = content_ff;
      wlo_in      = wlo_ff;
      whi_in      = whi_ff;
      hhi_in      = hhi_ff;
      prod_in     = prod_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      strcnt_in   = strcnt_ff;
      pixleft_in  = pixleft_ff;
      pixphase_in = pixphase_ff;
      partial_in  = partial_ff;
      err_in      = err_ff;
      code_in     = code_ff;
      clear_run   = 1'b0;
      e           = 1'b0;
      ecode       = aicv_pkg::E_HTYPE;
      pix_emit    = 1'b0;
      pix_blue    = b;
      stat_emit   = 1'b0;
      stat_kind   = aicv_pkg::KIND_ACCEPT;
      stat_code   = aicv_pkg::E_HTYPE;
      stat_eof    = 1'b0;

      // shared little-endian length gathering
      case (phase_ff)
         PH_HLEN, PH_HSIZE, PH_HCOUNT, PH_BLEN, PH_CLEN, PH_DUR, PH_IHSIZE,
         PH_ICSIZE, PH_IW, PH_IH: begin
            acc_in = gdone ? 64'd0 : v;
            cnt_in = gdone ? 4'd0 : cnt_ff + 4'd1;
         end
         default: ;
      endcase

      if (err_ff) begin
         if (fin) begin
            stat_emit = 1'b1;
            stat_kind = aicv_pkg::KIND_ERROR;
            stat_code = code_ff;
            stat_eof  = 1'b1;
            clear_run = 1'b1;
         end
      end else begin
         if (offset_ff >= cfg.file_length) begin
            e     = 1'b1;
            ecode = aicv_pkg::E_TRUNC;
         end else begin
            offset_in = pos1[31:0];
            unique case (phase_ff)
               PH_HTYPE: begin
                  if (b != aicv_pkg::ID_HEADER) begin
                     e = 1'b1; ecode = aicv_pkg::E_HTYPE;
                  end else begin
                     phase_in = PH_HLEN;
                  end
               end
               PH_HLEN: begin
                  if (gdone) begin
                     if (len_bad) begin
                        e = 1'b1; ecode = aicv_pkg::E_BLOCKLEN;
                     end else begin
                        phase_in = PH_MAGIC;
                     end
                  end
               end
               PH_MAGIC, PH_IMAGIC: begin
                  if (phase_ff == PH_IMAGIC && cnt_ff == 4'd0) hend_in = {1'b0, offset_ff};
                  if (b != ((phase_ff == PH_MAGIC) ? aicv_pkg::main_magic(cnt_ff[1:0])
                                                   : aicv_pkg::image_magic(cnt_ff[1:0])))
                  begin
                     e = 1'b1; ecode = aicv_pkg::E_MAGIC;
                  end else if (cnt_ff == 4'(aicv_pkg::MAGIC_BYTES - 1)) begin
                     cnt_in   = 4'd0;
                     phase_in = (phase_ff == PH_MAGIC) ? PH_HSIZE : PH_IHSIZE;
                  end else begin
                     cnt_in = cnt_ff + 4'd1;
                  end
               end
               PH_HSIZE: begin
                  if (gdone) begin
                     if (v != 64'(aicv_pkg::MAIN_HEADER_BYTES)) begin
                        e = 1'b1; ecode = aicv_pkg::E_HSIZE;
                     end else begin
                        phase_in = PH_HCOUNT;
                     end
                  end
               end
               PH_HCOUNT: begin
                  if (gdone) begin
                     declared_in = v;
                     phase_in    = PH_BOUND;
                  end
               end
               PH_BOUND: begin
                  if (pos1 != fl33) begin
                     btype_in = b;
                     phase_in = PH_BLEN;
                  end
               end
               PH_BLEN: begin
                  if (gdone) begin
                     if (len_bad) begin
                        e = 1'b1; ecode = aicv_pkg::E_BLOCKLEN;
                     end else if (btype_ff == aicv_pkg::ID_CREDITS) begin
                        phase_in = (aicv_pkg::DATE_BYTES > 0) ? PH_DATE : PH_CLEN;
                     end else if (btype_ff == aicv_pkg::ID_ANIM) begin
                        if (seen64 >= declared_ff) begin
                           e = 1'b1; ecode = aicv_pkg::E_MANY;
                        end else begin
                           if (seen_ff != 16'hFFFF) seen_in = seen_ff + 16'd1;
                           phase_in = PH_DUR;
                        end
                     end else begin
                        e = 1'b1; ecode = aicv_pkg::E_BTYPE;
                     end
                  end
               end
               PH_DATE: begin
                  if (cnt_ff >= 4'(aicv_pkg::DATE_BYTES - 1)) begin
                     cnt_in   = 4'd0;
                     phase_in = PH_CLEN;
                  end else begin
                     cnt_in = cnt_ff + 4'd1;
                  end
               end
               PH_CLEN: begin
                  if (gdone) begin
                     if (v > {48'd0, cfg.max_creator_length}) begin
                        e = 1'b1; ecode = aicv_pkg::E_CREATOR;
                     end else begin
                        strcnt_in = v[15:0];
                        phase_in  = (v != 64'd0) ? PH_CREATOR : PH_BOUND;
                     end
                  end
               end
               PH_CREATOR: begin
                  strcnt_in = sdec;
                  if (sdec == 16'd0) phase_in = PH_BOUND;
               end
               PH_DUR: begin
                  if (gdone) phase_in = PH_IMAGIC;
               end
               PH_IHSIZE: begin
                  if (gdone) begin
                     if (v > {48'd0, cfg.max_image_header_size}) begin
                        e = 1'b1; ecode = aicv_pkg::E_IHDR;
                     end else begin
                        hend_in  = hend_ff + {17'd0, v[15:0]};
                        phase_in = PH_ICSIZE;
                     end
                  end
               end
               PH_ICSIZE: begin
                  if (gdone) begin
                     if (v > {32'd0, cfg.max_image_content_size}) begin
                        e = 1'b1; ecode = aicv_pkg::E_CONTENT;
                     end else begin
                        content_in = v[31:0];
                        phase_in   = PH_IW;
                     end
                  end
               end
               PH_IW: begin
                  if (gdone) begin
                     wlo_in   = v[31:0];
                     whi_in   = (v[63:32] != 32'd0);
                     hhi_in   = 1'b0;
                     prod_in  = 64'd0;
                     phase_in = PH_IH;
                  end
               end
               PH_IH: begin
                  // build width * height one height byte at a time
                  if (cnt_ff < 4'd4) begin
                     prod_in = prod_ff + ({24'd0, part} << {cnt_ff[1:0], 3'b000});
                  end else begin
                     hhi_in = h_hi;
                  end
                  if (gdone) begin
                     if (!match) begin
                        e = 1'b1; ecode = aicv_pkg::E_MISMATCH;
                     end else begin
                        width_in   = wlo_ff;
                        height_in  = v[31:0];
                        pixleft_in = prod_ff[31:0];
                        strcnt_in  = 16'd0;
                        phase_in   = PH_CAPTION;
                     end
                  end
               end
               PH_CAPTION, PH_TAG: begin
                  if (term) begin
                     strcnt_in = 16'd0;
                     if (pos1 == hend_ff) begin
                        pixphase_in = 2'd0;
                        phase_in    = (pixleft_ff != 32'd0) ? PH_PIXEL : PH_BOUND;
                     end else if (pos1 > hend_ff) begin
                        e = 1'b1; ecode = aicv_pkg::E_HDREND;
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end else if (({1'b0, offset_ff} > hend_ff) || (strcnt_ff > lim)) begin
                     e = 1'b1; ecode = is_cap ? aicv_pkg::E_CAPTION : aicv_pkg::E_TAG;
                  end else begin
                     strcnt_in = strcnt_ff + 16'd1;
                  end
               end
               PH_PIXEL: begin
                  if (pixphase_ff == 2'd0) begin
                     partial_in  = {8'd0, b};
                     pixphase_in = 2'd1;
                  end else if (pixphase_ff == 2'd1) begin
                     partial_in  = {b, partial_ff[7:0]};
                     pixphase_in = 2'd2;
                  end else begin
                     pix_emit    = 1'b1;
                     pixphase_in = 2'd0;
                     pixleft_in  = pixleft_ff - 32'd1;
                     if (pixleft_ff == 32'd1) phase_in = PH_BOUND;
                  end
               end
               PH_DRAIN: ;
               default: ;
            endcase
         end

         if (!e && fin) begin
            if (phase_in != PH_BOUND || pos1 != fl33) begin
               e = 1'b1; ecode = aicv_pkg::E_TRUNC;
            end else if ({48'd0, seen_in} < declared_in) begin
               e = 1'b1; ecode = aicv_pkg::E_FEW;
            end else begin
               stat_emit = 1'b1;
               stat_kind = aicv_pkg::KIND_ACCEPT;
               stat_eof  = 1'b1;
               clear_run = 1'b1;
            end
         end
         if (e) begin
            err_in    = 1'b1;
            code_in   = ecode;
            stat_emit = 1'b1;
            stat_kind = aicv_pkg::KIND_ERROR;
            stat_code = ecode;
            stat_eof  = fin;
            if (fin) clear_run = 1'b1;
            else phase_in = PH_DRAIN;
         end
      end
   end

   // pixel first, then status
   always_comb begin
      aicv_pkg::rsp_type pix;
      aicv_pkg::rsp_type stat;
      pix.kind         = aicv_pkg::KIND_PIXEL;
      pix.error_code   = 4'd0;
      pix.image_index  = seen_in - 16'd1;
      pix.red          = partial_ff[7:0];
      pix.green        = partial_ff[15:8];
      pix.blue         = pix_blue;
      pix.image_width  = width_in;
      pix.image_height = height_in;
      pix.images_found = seen_in;
      pix.end_of_file  = 1'b0;
      stat.kind         = stat_kind;
      stat.error_code   = (stat_kind == aicv_pkg::KIND_ERROR) ? stat_code : 4'd0;
      stat.image_index  = 16'd0;
      stat.red          = 8'd0;
      stat.green        = 8'd0;
      stat.blue         = 8'd0;
      stat.image_width  = width_in;
      stat.image_height = height_in;
      stat.images_found = seen_in;
      stat.end_of_file  = stat_eof;
      push_first  = pix_emit ? pix : stat;
      push_second = stat;
      if (!in_accept) push_count = 2'd0;
      else push_count = {1'b0, pix_emit} + {1'b0, stat_emit};
   end

   always_ff @(posedge clock) begin
      if (reset || (in_accept && clear_run)) begin
         phase_ff    <= PH_HTYPE;
         cnt_ff      <= '0;
         acc_ff      <= '0;
         offset_ff   <= '0;
         btype_ff    <= '0;
         declared_ff <= '0;
         seen_ff     <= '0;
         hend_ff     <= '0;
         content_ff  <= '0;
         wlo_ff      <= '0;
         whi_ff      <= 1'b0;
         hhi_ff      <= 1'b0;
         prod_ff     <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         strcnt_ff   <= '0;
         pixleft_ff  <= '0;
         pixphase_ff <= '0;
         partial_ff  <= '0;
         err_ff      <= 1'b0;
         code_ff     <= '0;
      end else if (in_accept) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         acc_ff      <= acc_in;
         offset_ff   <= offset_in;
         btype_ff    <= btype_in;
         declared_ff <= declared_in;
         seen_ff     <= seen_in;
         hend_ff     <= hend_in;
         content_ff  <= content_in;
         wlo_ff      <= wlo_in;
         whi_ff      <= whi_in;
         hhi_ff      <= hhi_in;
         prod_ff     <= prod_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         strcnt_ff   <= strcnt_in;
         pixleft_ff  <= pixleft_in;
         pixphase_ff <= pixphase_in;
         partial_ff  <= partial_in;
         err_ff      <= err_in;
         code_ff     <= code_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/aicv_out_fifo.sv =====
// Small result queue taking up to two results per cycle and giving one per cycle while the output is not stalled.
`default_nettype none
module aicv_out_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [1:0]             push_count,
   input  aicv_pkg::rsp_type     push_first,
   input  aicv_pkg::rsp_type     push_second,
   output logic                  room_for_two,
   output logic                  out_valid,
   input  wire                   out_stall,
   output aicv_pkg::rsp_type     out_data
);

   localparam int PW = $clog2(aicv_pkg::FIFO_DEPTH);

   aicv_pkg::rsp_type entry_ff [aicv_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;
   logic          pop;
   logic [PW-1:0] wr_next;

   always_comb begin
      out_valid    = (count_ff != '0);
      pop          = out_valid && !out_stall;
      wr_next      = wr_ff + PW'(1);
      wr_in        = wr_ff + PW'(push_count);
      rd_in        = pop ? rd_ff + PW'(1) : rd_ff;
      count_in     = count_ff + (PW+1)'(push_count) - (PW+1)'(pop);
      out_data     = entry_ff[rd_ff];
      room_for_two = (count_ff <= (PW+1)'(aicv_pkg::FIFO_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) entry_ff[wr_ff] <= push_first;
      if (push_count == 2'd2) entry_ff[wr_next] <= push_second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/animated_image_container_validator.sv =====
// Top level: control registers, byte parser and result queue.
// A result is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while req_stall is low; each byte yields at most two results (pixel, status).
// req_stall rises only while the four-entry result queue cannot take two more results.
// Reset (synchronous, active high) clears parser state and the queue and restores
// the register defaults; after each status that ends a file the parser restarts.
`default_nettype none
module animated_image_container_validator (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  aicv_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output aicv_pkg::rsp_type     rsp_data,
   input  wire                   csr_write_enable,
   input  wire [2:0]             csr_index,
   input  wire [31:0]            csr_write_data
);

   aicv_pkg::cfg_type cfg_ff;
   aicv_pkg::rsp_type push_first;
   aicv_pkg::rsp_type push_second;
   logic [1:0]        push_count;
   logic              room_for_two;
   logic              req_accept;

   assign req_stall  = !room_for_two;
   assign req_accept = req_valid && room_for_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_length            <= 32'd0;
         cfg_ff.max_creator_length     <= 16'd256;
         cfg_ff.max_image_header_size  <= 16'd4096;
         cfg_ff.max_image_content_size <= 32'd16777216;
         cfg_ff.max_caption_length     <= 16'd1024;
         cfg_ff.max_tag_length         <= 16'd1024;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aicv_pkg::CSR_FILE_LENGTH: cfg_ff.file_length <= csr_write_data;
            aicv_pkg::CSR_MAX_CREATOR: cfg_ff.max_creator_length <= csr_write_data[15:0];
            aicv_pkg::CSR_MAX_IHEADER: cfg_ff.max_image_header_size <= csr_write_data[15:0];
            aicv_pkg::CSR_MAX_CONTENT: cfg_ff.max_image_content_size <= csr_write_data;
            aicv_pkg::CSR_MAX_CAPTION: cfg_ff.max_caption_length <= csr_write_data[15:0];
            aicv_pkg::CSR_MAX_TAG:     cfg_ff.max_tag_length <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   aicv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (req_accept),
      .in_data     (req_data),
      .cfg         (cfg_ff),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second)
   );

   aicv_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (push_first),
      .push_second  (push_second),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_data     (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sim/aicv_result_checker.sv =====
// Result checker for the animated image container validator: predicts and compares.
`timescale 1ns / 100ps
module aicv_result_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  aicv_pkg::req_type   req_data,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  aicv_pkg::rsp_type   rsp_data,
   input  wire                 csr_write_enable,
   input  wire [2:0]           csr_index,
   input  wire [31:0]          csr_write_data,
   output int                  failures,
   output int                  outstanding
);

   typedef enum int {
      P_HTYPE, P_HLEN, P_MAGIC, P_HSIZE, P_HCOUNT, P_BOUND, P_BLEN, P_DATE, P_CLEN,
      P_CREATOR, P_DUR, P_IMAGIC, P_IHSIZE, P_ICSIZE, P_IW, P_IH, P_CAPTION, P_TAG,
      P_PIXEL, P_DRAIN
   } parse_phase_type;

   logic [63:0] lim_file, lim_creator, lim_iheader, lim_content, lim_caption, lim_tag;

   parse_phase_type phase;
   int unsigned  field_cnt;
   logic [63:0]  acc;
   logic [31:0]  offset;
   logic [7:0]   cur_block_id;
   logic [63:0]  declared;
   logic [15:0]  seen;
   logic [63:0]  hdr_end;
   logic [63:0]  content;
   logic [31:0]  width_q, height_q;
   logic [31:0]  str_count;
   logic [63:0]  pixels_left;
   int unsigned  pix_phase;
   logic [15:0]  partial_rg;
   logic         err_held;
   logic [3:0]   held_code;

   aicv_pkg::rsp_type expected_results[$];

   assign outstanding = expected_results.size();

   function automatic logic [7:0] image_sig(int unsigned i);
      logic [7:0] r;
      case (i & 3)
         0:       r = 8'h43;
         1:       r = 8'h49;
         default: r = 8'h46;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] main_sig(int unsigned i);
      logic [7:0] r;
      case (i & 3)
         0:       r = 8'h43;
         1:       r = 8'h41;
         default: r = 8'h46;
      endcase
      return r;
   endfunction

   task automatic restart_file();
      phase = P_HTYPE;
      field_cnt = 0;
      acc = 0;
      offset = 0;
      cur_block_id = 0;
      declared = 0;
      seen = 0;
      hdr_end = 0;
      content = 0;
      width_q = 0;
      height_q = 0;
      str_count = 0;
      pixels_left = 0;
      pix_phase = 0;
      partial_rg = 0;
      err_held = 0;
      held_code = 0;
   endtask

   task automatic push_result(logic [1:0] kind, logic [3:0] code, logic [15:0] idx,
                              logic [7:0] r, logic [7:0] g, logic [7:0] bl, logic eof);
      aicv_pkg::rsp_type x;
      x.kind = kind;
      x.error_code = code;
      x.image_index = idx;
      x.red = r;
      x.green = g;
      x.blue = bl;
      x.image_width = width_q;
      x.image_height = height_q;
      x.images_found = seen;
      x.end_of_file = eof;
      expected_results.push_back(x);
   endtask

   // little-endian field assembly; returns 1 when the field is complete
   function automatic bit gather_field(logic [7:0] b, output logic [63:0] v);
      acc = acc | (64'(b) << (8 * (field_cnt & 7)));
      field_cnt++;
      v = 0;
      if (field_cnt < aicv_pkg::LENGTH_BYTES) return 0;
      v = acc;
      acc = 0;
      field_cnt = 0;
      return 1;
   endfunction

   function automatic bit size_matches(logic [63:0] c, logic [63:0] w, logic [63:0] h);
      logic [63:0] q;
      if (w == 0 || h == 0) return c == 0;
      if (c % 3 != 0) return 0;
      q = c / 3;
      return (q % w == 0) && (q / w == h);
   endfunction

   task automatic parse_byte(logic [7:0] b, logic [63:0] pos, output int e);
      logic [63:0] v;
      logic        term;
      logic [63:0] lim;
      e = -1;
      case (phase)
         P_HTYPE:
            if (b != aicv_pkg::ID_HEADER) e = aicv_pkg::E_HTYPE;
            else phase = P_HLEN;
         P_HLEN:
            if (gather_field(b, v)) begin
               if (v > lim_file - (pos + 1)) e = aicv_pkg::E_BLOCKLEN;
               else phase = P_MAGIC;
            end
         P_MAGIC:
            if (b != main_sig(field_cnt)) e = aicv_pkg::E_MAGIC;
            else begin
               field_cnt++;
               if (field_cnt >= aicv_pkg::MAGIC_BYTES) begin
                  field_cnt = 0;
                  phase = P_HSIZE;
               end
            end
         P_HSIZE:
            if (gather_field(b, v)) begin
               if (v != aicv_pkg::MAIN_HEADER_BYTES) e = aicv_pkg::E_HSIZE;
               else phase = P_HCOUNT;
            end
         P_HCOUNT:
            if (gather_field(b, v)) begin
               declared = v;
               phase = P_BOUND;
            end
         P_BOUND:
            if (pos + 1 != lim_file) begin
               cur_block_id = b;
               phase = P_BLEN;
            end
         P_BLEN:
            if (gather_field(b, v)) begin
               if (v > lim_file - (pos + 1)) e = aicv_pkg::E_BLOCKLEN;
               else if (cur_block_id == aicv_pkg::ID_CREDITS)
                  phase = (aicv_pkg::DATE_BYTES > 0) ? P_DATE : P_CLEN;
               else if (cur_block_id == aicv_pkg::ID_ANIM) begin
                  if (64'(seen) >= declared) e = aicv_pkg::E_MANY;
                  else begin
                     if (seen != 16'hFFFF) seen++;
                     phase = P_DUR;
                  end
               end else e = aicv_pkg::E_BTYPE;
            end
         P_DATE: begin
            field_cnt++;
            if (field_cnt >= aicv_pkg::DATE_BYTES) begin
               field_cnt = 0;
               phase = P_CLEN;
            end
         end
         P_CLEN:
            if (gather_field(b, v)) begin
               if (v > lim_creator) e = aicv_pkg::E_CREATOR;
               else begin
                  str_count = v[31:0];
                  phase = (v != 0) ? P_CREATOR : P_BOUND;
               end
            end
         P_CREATOR: begin
            if (str_count > 0) str_count--;
            if (str_count == 0) phase = P_BOUND;
         end
         P_DUR:
            if (gather_field(b, v)) phase = P_IMAGIC;
         P_IMAGIC: begin
            if (field_cnt == 0) hdr_end = pos;
            if (b != image_sig(field_cnt)) e = aicv_pkg::E_MAGIC;
            else begin
               field_cnt++;
               if (field_cnt >= aicv_pkg::MAGIC_BYTES) begin
                  field_cnt = 0;
                  phase = P_IHSIZE;
               end
            end
         end
         P_IHSIZE:
            if (gather_field(b, v)) begin
               if (v > lim_iheader) e = aicv_pkg::E_IHDR;
               else begin
                  hdr_end = hdr_end + v;
                  phase = P_ICSIZE;
               end
            end
         P_ICSIZE:
            if (gather_field(b, v)) begin
               if (v > lim_content) e = aicv_pkg::E_CONTENT;
               else begin
                  content = v;
                  phase = P_IW;
               end
            end
         P_IW:
            // width parks in pixels_left until the height arrives
            if (gather_field(b, v)) begin
               pixels_left = v;
               phase = P_IH;
            end
         P_IH:
            if (gather_field(b, v)) begin
               if (!size_matches(content, pixels_left, v)) e = aicv_pkg::E_MISMATCH;
               else begin
                  width_q = pixels_left[31:0];
                  height_q = v[31:0];
                  pixels_left = content / aicv_pkg::PIXEL_BYTES;
                  str_count = 0;
                  phase = P_CAPTION;
               end
            end
         P_CAPTION, P_TAG: begin
            term = (phase == P_CAPTION) ? (b == aicv_pkg::CHAR_NL) : (b == aicv_pkg::CHAR_NUL);
            lim = (phase == P_CAPTION) ? lim_caption : lim_tag;
            if (term) begin
               str_count = 0;
               if (pos + 1 == hdr_end) begin
                  pix_phase = 0;
                  phase = (pixels_left != 0) ? P_PIXEL : P_BOUND;
               end else if (pos + 1 > hdr_end) e = aicv_pkg::E_HDREND;
               else phase = P_TAG;
            end else if (pos > hdr_end || 64'(str_count) > lim) begin
               e = (phase == P_CAPTION) ? aicv_pkg::E_CAPTION : aicv_pkg::E_TAG;
            end else str_count++;
         end
         P_PIXEL:
            if (pix_phase == 0) begin
               partial_rg = {8'h00, b};
               pix_phase = 1;
            end else if (pix_phase == 1) begin
               partial_rg[15:8] = b;
               pix_phase = 2;
            end else begin
               push_result(aicv_pkg::KIND_PIXEL, 4'd0, seen - 16'd1, partial_rg[7:0],
                           partial_rg[15:8], b, 1'b0);
               pix_phase = 0;
               pixels_left--;
               if (pixels_left == 0) phase = P_BOUND;
            end
         default: ;
      endcase
   endtask

   task automatic predict_byte(logic [7:0] b, logic fin);
      int          e;
      logic [63:0] pos;
      if (err_held) begin
         if (fin) begin
            push_result(aicv_pkg::KIND_ERROR, held_code, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1);
            restart_file();
         end
         return;
      end
      pos = 64'(offset);
      if (pos >= lim_file) e = aicv_pkg::E_TRUNC;
      else begin
         parse_byte(b, pos, e);
         offset = pos[31:0] + 32'd1;
      end
      if (e < 0 && fin) begin
         if (phase != P_BOUND || pos + 1 != lim_file) e = aicv_pkg::E_TRUNC;
         else if (64'(seen) < declared) e = aicv_pkg::E_FEW;
         else begin
            push_result(aicv_pkg::KIND_ACCEPT, 4'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1);
            restart_file();
            return;
         end
      end
      if (e >= 0) begin
         err_held = 1;
         held_code = e[3:0];
         push_result(aicv_pkg::KIND_ERROR, held_code, 16'd0, 8'd0, 8'd0, 8'd0, fin);
         if (fin) restart_file();
         else phase = P_DRAIN;
      end
   endtask

   always @(posedge clock) begin
      aicv_pkg::rsp_type want;
      if (reset) begin
         lim_file = 0;
         lim_creator = 256;
         lim_iheader = 4096;
         lim_content = 16777216;
         lim_caption = 1024;
         lim_tag = 1024;
         restart_file();
         expected_results.delete();
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected result %h", $time, rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data !== want) begin
                  failures++;
                  $display({"%0t: mismatch expected kind=%0d code=%0d idx=%0d rgb=%h%h%h",
                            " w=%0d h=%0d n=%0d eof=%0d"},
                           $time, want.kind, want.error_code, want.image_index, want.red,
                           want.green, want.blue, want.image_width, want.image_height,
                           want.images_found, want.end_of_file);
                  $display({"%0t:          actual   kind=%0d code=%0d idx=%0d rgb=%h%h%h",
                            " w=%0d h=%0d n=%0d eof=%0d"},
                           $time, rsp_data.kind, rsp_data.error_code, rsp_data.image_index,
                           rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.image_width,
                           rsp_data.image_height, rsp_data.images_found, rsp_data.end_of_file);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               aicv_pkg::CSR_FILE_LENGTH: lim_file = 64'(csr_write_data);
               aicv_pkg::CSR_MAX_CREATOR: lim_creator = 64'(csr_write_data[15:0]);
               aicv_pkg::CSR_MAX_IHEADER: lim_iheader = 64'(csr_write_data[15:0]);
               aicv_pkg::CSR_MAX_CONTENT: lim_content = 64'(csr_write_data);
               aicv_pkg::CSR_MAX_CAPTION: lim_caption = 64'(csr_write_data[15:0]);
               aicv_pkg::CSR_MAX_TAG:     lim_tag = 64'(csr_write_data[15:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_byte(req_data.byte_value, req_data.is_final);
      end
   end

endmodule

// ===== sim/animated_image_container_validator_test.sv =====
// Testbench top: container file stimulus, register setup and final verdict.
`timescale 1ns / 100ps
module animated_image_container_validator_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEM_GOAL   = 1750;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   aicv_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   aicv_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 0;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_write_data = '0;
   int                failures;
   int                outstanding;
   int                cycles = 0;
   int                sent = 0;
   int                stall_hold = 0;
   logic [7:0]        file_bytes[$];

   animated_image_container_validator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   aicv_result_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures), .outstanding(outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver back-pressure: short bursts, occasional long stalls or clear stretches
   always @(posedge clock) begin
      if (!reset) begin
         if (stall_hold > 0) stall_hold <= stall_hold - 1;
         else begin
            case ($urandom_range(0, 9))
               0:       begin rsp_stall <= 1; stall_hold <= $urandom_range(10, 40); end
               1:       begin rsp_stall <= 0; stall_hold <= $urandom_range(20, 60); end
               default: begin
                  rsp_stall <= ($urandom_range(0, 2) == 0);
                  stall_hold <= $urandom_range(0, 3);
               end
            endcase
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic fin);
      int gap;
      case ($urandom_range(0, 19))
         14, 15, 16, 17, 18: gap = $urandom_range(1, 3);
         19:                 gap = $urandom_range(10, 30);
         default:            gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{byte_value: b, is_final: fin};
      // hold until the transfer
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      req_valid <= 0;
   endtask

   // drain all results and let the parser settle before touching registers
   task automatic wait_idle();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick16();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 32'($urandom_range(1, 3));
         2:       return 32'hFFFF;
         default: return 32'($urandom_range(4, 65534));
      endcase
   endfunction

   task automatic write_regs(logic [31:0] flen, bit all_limits);
      logic [31:0] vals[6];
      int          last;
      vals[0] = flen;
      vals[1] = pick16();
      vals[2] = ($urandom_range(0, 4) == 0) ? pick16() : 32'($urandom_range(36, 65535));
      case ($urandom_range(0, 4))
         0:       vals[3] = 0;
         1:       vals[3] = 32'($urandom_range(0, 30));
         2:       vals[3] = 32'hFFFF_FFFF;
         default: vals[3] = 16777216;
      endcase
      vals[4] = pick16();
      vals[5] = pick16();
      last = all_limits ? 5 : 0;
      for (int i = 0; i <= last; i++) begin
         csr_write_enable <= 1;
         csr_index <= 3'(i);
         csr_write_data <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 0;
   endtask

   function automatic void put_le(ref logic [7:0] q[$], input logic [63:0] v);
      for (int i = 0; i < aicv_pkg::LENGTH_BYTES; i++) q.push_back(v[8*i +: 8]);
   endfunction

   function automatic void add_block(logic [7:0] id, ref logic [7:0] body[$]);
      logic [63:0] len;
      len = 64'(body.size());
      if ($urandom_range(0, 19) == 0) len = len + 64'($urandom_range(1, 1000));
      file_bytes.push_back(id);
      put_le(file_bytes, len);
      foreach (body[i]) file_bytes.push_back(body[i]);
   endfunction

   function automatic void add_credits();
      logic [7:0] body[$];
      int         n;
      n = $urandom_range(0, 4);
      for (int i = 0; i < aicv_pkg::DATE_BYTES; i++) body.push_back(8'($urandom));
      put_le(body, 64'(n));
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      add_block(aicv_pkg::ID_CREDITS, body);
   endfunction

   function automatic void add_animation();
      logic [7:0]  body[$];
      logic [7:0]  strs[$];
      logic [7:0]  c;
      logic [63:0] w, h, csize;
      int          ntags, n;
      w = 64'($urandom_range(0, 3));
      h = 64'($urandom_range(0, 3));
      csize = w * h * 3;
      if ($urandom_range(0, 15) == 0) csize = csize + 64'd3;
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         do c = 8'($urandom); while (c == aicv_pkg::CHAR_NL);
         strs.push_back(c);
      end
      strs.push_back(aicv_pkg::CHAR_NL);
      ntags = $urandom_range(0, 2);
      for (int t = 0; t < ntags; t++) begin
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) strs.push_back(8'($urandom_range(1, 255)));
         strs.push_back(aicv_pkg::CHAR_NUL);
      end
      put_le(body, {$urandom, $urandom});
      body.push_back(8'h43);
      body.push_back(8'h49);
      body.push_back(8'h46);
      body.push_back(8'h46);
      put_le(body, 64'(36 + strs.size()));
      put_le(body, csize);
      put_le(body, w);
      put_le(body, h);
      foreach (strs[i]) body.push_back(strs[i]);
      for (int i = 0; i < w * h * 3; i++) body.push_back(8'($urandom));
      add_block(aicv_pkg::ID_ANIM, body);
   endfunction

   // builds a file and returns the file_length to program
   function automatic logic [31:0] build_file();
      int          ncred, nanim, declared, pos;
      logic [31:0] flen;
      file_bytes.delete();
      ncred = $urandom_range(0, 2);
      nanim = $urandom_range(0, 2);
      declared = nanim;
      if ($urandom_range(0, 9) == 0) declared = nanim + 1;
      if ($urandom_range(0, 9) == 0 && nanim > 0) declared = nanim - 1;
      file_bytes.push_back(aicv_pkg::ID_HEADER);
      put_le(file_bytes, 64'(aicv_pkg::MAIN_HEADER_BYTES));
      file_bytes.push_back(8'h43);
      file_bytes.push_back(8'h41);
      file_bytes.push_back(8'h46);
      file_bytes.push_back(8'h46);
      put_le(file_bytes, 64'(aicv_pkg::MAIN_HEADER_BYTES));
      put_le(file_bytes, 64'(declared));
      while (ncred + nanim > 0) begin
         if (nanim == 0 || (ncred > 0 && $urandom_range(0, 1) == 0)) begin
            add_credits();
            ncred--;
         end else begin
            add_animation();
            nanim--;
         end
      end
      flen = 32'(file_bytes.size());
      case ($urandom_range(0, 19))
         0, 1: begin
            pos = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[pos] = 8'($urandom);
         end
         2: file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
         3: file_bytes.push_back(8'($urandom));
         4: flen = flen + 32'($urandom_range(0, 2)) - 32'd1;
         5, 6: begin
            // one stray byte past the last block
            file_bytes.push_back(8'($urandom));
            flen = 32'(file_bytes.size());
         end
         7: flen = 32'hFFFF_FFFF;
         default: ;
      endcase
      return flen;
   endfunction

   initial begin
      logic [31:0] flen;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // short files: single byte with nothing allowed, single byte of wrong header type, and unterminated ones
      write_regs(32'd0, 1);
      send_byte(8'h01, 1);
      req_valid <= 0;
      wait_idle();
      write_regs(32'd5, 0);
      send_byte(8'hFF, 1);
      send_byte(8'h01, 0);
      send_byte(8'h00, 1);
      send_byte(8'h01, 0);
      send_byte(8'hAB, 0);
      send_byte(8'h00, 0);
      send_byte(8'h55, 1);
      req_valid <= 0;
      wait_idle();

      while (sent < ITEM_GOAL) begin
         flen = build_file();
         write_regs(flen, $urandom_range(0, 3) == 0);
         send_file();
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/aicv_pkg.sv
src/aicv_parser.sv
src/aicv_out_fifo.sv
src/animated_image_container_validator.sv
sim/aicv_result_checker.sv
sim/animated_image_container_validator_test.sv
